### hdl/tfs_pkg.sv
// Shared types and constants for the triangle fan subdivider.
package tfs_pkg;

    // Width of the split count configuration register.
    localparam int CFG_W = 7;

    // Number of vertices per triangle and coordinates per vertex.
    localparam int NUM_VERTS = 3;
    localparam int NUM_AXES  = 3;

    // Coordinate positions inside a vertex.
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    // Vertex codes used for apex selection.
    typedef enum logic [1:0] {
        VTX_A = 2'd0,
        VTX_B = 2'd1,
        VTX_C = 2'd2
    } t_vtx;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_STEP,
        S_EMIT
    } t_state;

    // Handshake between the sequencer and the shared divider.
    typedef struct packed {
        logic start;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic busy;
    } t_div_stat;

endpackage

### hdl/tfs_if.sv
// Channel interfaces: triangle requests, fan piece results and configuration writes.
interface tfs_tri_if #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    input ready);
    modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    output ready);
endinterface

interface tfs_piece_if #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] apex_x;
    logic signed [COORD_BITS-1:0] apex_y;
    logic signed [COORD_BITS-1:0] apex_z;
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_y;
    logic signed [COORD_BITS-1:0] near_z;
    logic signed [COORD_BITS-1:0] far_x;
    logic signed [COORD_BITS-1:0] far_y;
    logic signed [COORD_BITS-1:0] far_z;
    logic                         last_piece;

    modport source (output valid, apex_x, apex_y, apex_z, near_x, near_y, near_z,
                    far_x, far_y, far_z, last_piece, input ready);
    modport sink   (input valid, apex_x, apex_y, apex_z, near_x, near_y, near_z,
                    far_x, far_y, far_z, last_piece, output ready);
endinterface

interface tfs_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [tfs_pkg::CFG_W-1:0]  split_count;

    modport source (output valid, split_count, input ready);
    modport sink   (input valid, split_count, output ready);
endinterface

### hdl/tfs_div.sv
// Shared iterative restoring divider, one quotient bit per cycle.
module tfs_div #(
    parameter int DIVIDEND_W = 24,
    parameter int DIVISOR_W  = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tfs_pkg::t_div_req      i_req,
    input  logic [DIVIDEND_W-1:0]  i_dividend,
    input  logic [DIVISOR_W-1:0]   i_divisor,
    output tfs_pkg::t_div_stat     o_stat,
    output logic [DIVIDEND_W-1:0]  o_quot,
    output logic [DIVISOR_W-1:0]   o_rem
);
    import tfs_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_work, n_work;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVISOR_W-1:0]  r_dvs, n_dvs;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        shifted = {r_rem, r_work[DIVIDEND_W-1]};
        trial   = shifted - {1'b0, r_dvs};
        fits    = (shifted >= {1'b0, r_dvs});
    end

    // Next state of the divider.
    always_comb begin
        n_work = r_work;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_work = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_cnt  = CNT_W'(DIVIDEND_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_work = {r_work[DIVIDEND_W-2:0], fits};
            n_rem  = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers take reset; the datapath does not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_work <= n_work;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_stat.done = r_done;
    assign o_stat.busy = r_busy;
    assign o_quot      = r_work;
    assign o_rem       = r_rem;

endmodule

### hdl/triangle_fan_subdivide.sv
// Top level of the triangle fan subdivider: sequencer, step unit and output register.
//
// Each triangle request is split into a fan of n = min(split_count, MAX_PIECES)
// pieces sharing the apex (the vertex with strictly greatest Y, vertex 2 on ties);
// a count of zero returns the triangle unchanged as a single piece. The block
// works on one triangle at a time and is not ready while it does. With a nonzero
// count the edge opposite the apex is divided by n once per axis on the shared
// divider, and then each piece takes three accumulate steps on the shared adder,
// one per axis, and a load of the output register, which waits while the result
// side stalls.
// The output register lets the last piece wait while the next triangle is taken.
module triangle_fan_subdivide #(
    parameter int MAX_PIECES = 64,
    parameter int COORD_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tfs_cfg_if.sink      i_cfg,
    tfs_tri_if.sink      i_tri,
    tfs_piece_if.source  o_piece
);
    import tfs_pkg::*;

    localparam int N_W = $clog2(MAX_PIECES + 1);
    localparam int C_W = COORD_BITS;

    // Configuration register.
    logic [CFG_W-1:0] r_split_count;

    // Sequencer registers.
    t_state      r_state, n_state;
    logic [1:0]  r_ci, n_ci;
    logic [N_W-1:0] r_n;
    logic [N_W-1:0] r_k;
    logic        r_pass;

    // Triangle and accumulator registers, one entry per axis.
    logic signed [C_W-1:0] r_apex [NUM_AXES];
    logic signed [C_W-1:0] r_adj1 [NUM_AXES];
    logic signed [C_W-1:0] r_adj2 [NUM_AXES];
    logic signed [C_W-1:0] r_near [NUM_AXES];
    logic [C_W-1:0]        r_qdiv [NUM_AXES];
    logic [N_W-1:0]        r_rdiv [NUM_AXES];
    logic [C_W-1:0]        r_qacc [NUM_AXES];
    logic [N_W-1:0]        r_racc [NUM_AXES];
    logic                  r_neg  [NUM_AXES];

    // Output register.
    logic                  r_o_valid, n_o_valid;
    logic signed [C_W-1:0] r_o_apex [NUM_AXES];
    logic signed [C_W-1:0] r_o_near [NUM_AXES];
    logic signed [C_W-1:0] r_o_far  [NUM_AXES];
    logic                  r_o_last;

    // Input vertices as an array, vertex by axis.
    logic signed [C_W-1:0] in_v [NUM_VERTS][NUM_AXES];
    t_vtx                  apex_sel, adj1_sel, adj2_sel;
    logic [N_W-1:0]        eff_n;
    logic                  tri_acc;

    // Divider connection.
    t_div_req              div_req;
    t_div_stat             div_stat;
    logic [C_W-1:0]        div_quot;
    logic [N_W-1:0]        div_rem;
    logic signed [C_W:0]   edge_diff;
    logic [C_W:0]          edge_abs;

    // Step unit signals.
    logic [N_W:0]          step_rsum;
    logic [N_W:0]          step_rsub;
    logic                  step_wrap;
    logic [C_W-1:0]        step_qacc;
    logic [N_W-1:0]        step_racc;

    // Cut point per axis from the accumulated quotient.
    logic signed [C_W-1:0] far_pt [NUM_AXES];
    logic [C_W:0]          far_mag [NUM_AXES];
    logic [C_W:0]          far_off [NUM_AXES];
    logic [C_W:0]          far_sum [NUM_AXES];

    logic                  out_free;
    logic                  load_out;
    logic                  piece_last;
    logic [N_W-1:0]        n_minus1;

    // Gather the request payload.
    always_comb begin
        in_v[VTX_A][AXIS_X] = i_tri.a_x;
        in_v[VTX_A][AXIS_Y] = i_tri.a_y;
        in_v[VTX_A][AXIS_Z] = i_tri.a_z;
        in_v[VTX_B][AXIS_X] = i_tri.b_x;
        in_v[VTX_B][AXIS_Y] = i_tri.b_y;
        in_v[VTX_B][AXIS_Z] = i_tri.b_z;
        in_v[VTX_C][AXIS_X] = i_tri.c_x;
        in_v[VTX_C][AXIS_Y] = i_tri.c_y;
        in_v[VTX_C][AXIS_Z] = i_tri.c_z;
    end

    // Apex is the vertex with strictly greatest Y; vertex C wins any tie.
    always_comb begin
        if (i_tri.a_y > i_tri.b_y && i_tri.a_y > i_tri.c_y) begin
            apex_sel = VTX_A;
            adj1_sel = VTX_B;
            adj2_sel = VTX_C;
        end else if (i_tri.b_y > i_tri.a_y && i_tri.b_y > i_tri.c_y) begin
            apex_sel = VTX_B;
            adj1_sel = VTX_C;
            adj2_sel = VTX_A;
        end else begin
            apex_sel = VTX_C;
            adj1_sel = VTX_A;
            adj2_sel = VTX_B;
        end
    end

    // Piece count saturates at the configured maximum.
    assign eff_n = (r_split_count > CFG_W'(MAX_PIECES)) ? N_W'(MAX_PIECES)
                                                        : r_split_count[N_W-1:0];

    assign tri_acc     = i_tri.valid && i_tri.ready;
    assign i_tri.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // Configuration write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_count <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_split_count <= i_cfg.split_count;
        end
    end

    // Edge length magnitude for the current axis feeds the divider.
    always_comb begin
        edge_diff = {r_adj2[r_ci][C_W-1], r_adj2[r_ci]} - {r_adj1[r_ci][C_W-1], r_adj1[r_ci]};
        edge_abs  = edge_diff[C_W] ? (~edge_diff + 1'b1) : edge_diff;
    end

    assign div_req.start = (r_state == S_DIV_GO);

    tfs_div #(
        .DIVIDEND_W (C_W),
        .DIVISOR_W  (N_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (edge_abs[C_W-1:0]),
        .i_divisor  (r_n),
        .o_stat     (div_stat),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Shared step unit: advance the quotient and remainder of one axis by one piece.
    always_comb begin
        step_rsum = {1'b0, r_racc[r_ci]} + {1'b0, r_rdiv[r_ci]};
        step_wrap = (step_rsum >= {1'b0, r_n});
        step_rsub = step_rsum - {1'b0, r_n};
        step_racc = step_wrap ? step_rsub[N_W-1:0] : step_rsum[N_W-1:0];
        step_qacc = r_qacc[r_ci] + r_qdiv[r_ci] + C_W'(step_wrap);
    end

    // Cut point = adjacent vertex plus the signed accumulated offset.
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            far_mag[a] = {1'b0, r_qacc[a]};
            far_off[a] = r_neg[a] ? (~far_mag[a] + 1'b1) : far_mag[a];
            far_sum[a] = {r_adj1[a][C_W-1], r_adj1[a]} + far_off[a];
            far_pt[a]  = far_sum[a][C_W-1:0];
        end
    end

    assign n_minus1   = r_n - 1'b1;
    assign piece_last = r_pass || (r_k == n_minus1);
    assign out_free   = !r_o_valid || o_piece.ready;
    assign load_out   = (r_state == S_EMIT) && out_free;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        n_ci    = r_ci;
        case (r_state)
            S_IDLE: begin
                n_ci = 2'd0;
                if (tri_acc) begin
                    n_state = (eff_n == '0) ? S_EMIT : S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_stat.done) begin
                    if (r_ci == 2'(NUM_AXES - 1)) begin
                        n_ci    = 2'd0;
                        n_state = S_STEP;
                    end else begin
                        n_ci    = r_ci + 1'b1;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_STEP: begin
                if (r_ci == 2'(NUM_AXES - 1)) begin
                    n_ci    = 2'd0;
                    n_state = S_EMIT;
                end else begin
                    n_ci = r_ci + 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = piece_last ? S_IDLE : S_STEP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid next value.
    always_comb begin
        if (load_out) begin
            n_o_valid = 1'b1;
        end else if (o_piece.ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ci      <= 2'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ci      <= n_ci;
            r_o_valid <= n_o_valid;
        end
    end

    // Triangle capture, divider results, accumulation and piece counter.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && tri_acc) begin
            r_n    <= eff_n;
            r_k    <= '0;
            r_pass <= (eff_n == '0);
            for (int a = 0; a < NUM_AXES; a++) begin
                if (eff_n == '0) begin
                    r_apex[a] <= in_v[VTX_A][a];
                    r_adj1[a] <= in_v[VTX_B][a];
                    r_adj2[a] <= in_v[VTX_C][a];
                    r_near[a] <= in_v[VTX_B][a];
                end else begin
                    r_apex[a] <= in_v[apex_sel][a];
                    r_adj1[a] <= in_v[adj1_sel][a];
                    r_adj2[a] <= in_v[adj2_sel][a];
                    r_near[a] <= in_v[adj1_sel][a];
                end
            end
        end
        if (r_state == S_DIV_GO) begin
            r_neg[r_ci] <= edge_diff[C_W];
        end
        if (r_state == S_DIV_WAIT && div_stat.done) begin
            r_qdiv[r_ci] <= div_quot;
            r_rdiv[r_ci] <= div_rem;
            r_qacc[r_ci] <= '0;
            r_racc[r_ci] <= '0;
        end
        if (r_state == S_STEP) begin
            r_qacc[r_ci] <= step_qacc;
            r_racc[r_ci] <= step_racc;
        end
        if (load_out) begin
            r_k <= r_k + 1'b1;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_near[a] <= far_pt[a];
            end
        end
    end

    // Output register load.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_last <= piece_last;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_o_apex[a] <= r_apex[a];
                r_o_near[a] <= r_near[a];
                r_o_far[a]  <= r_pass ? r_adj2[a] : far_pt[a];
            end
        end
    end

    // Drive the result channel.
    assign o_piece.valid      = r_o_valid;
    assign o_piece.apex_x     = r_o_apex[AXIS_X];
    assign o_piece.apex_y     = r_o_apex[AXIS_Y];
    assign o_piece.apex_z     = r_o_apex[AXIS_Z];
    assign o_piece.near_x     = r_o_near[AXIS_X];
    assign o_piece.near_y     = r_o_near[AXIS_Y];
    assign o_piece.near_z     = r_o_near[AXIS_Z];
    assign o_piece.far_x      = r_o_far[AXIS_X];
    assign o_piece.far_y      = r_o_far[AXIS_Y];
    assign o_piece.far_z      = r_o_far[AXIS_Z];
    assign o_piece.last_piece = r_o_last;

endmodule

### hdl/tfs_chk.sv
// Port-level checker for the triangle fan subdivider, bound to the top level.
module tfs_chk #(
    parameter int COORD_BITS = 24
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic                  i_out_last,
    input logic [COORD_BITS-1:0] i_out_far_x
);
    logic in_acc;
    logic out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_last) && $stable(i_out_far_x))
        else $error("stalled result changed");

    // Once a triangle is taken the block is busy with it.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("ready right after taking a triangle");

    // While more pieces of a triangle are owed, no new triangle is taken.
    a_no_take_mid_fan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !i_out_last |-> !i_in_ready)
        else $error("ready before the last piece was produced");

endmodule

bind triangle_fan_subdivide tfs_chk #(
    .COORD_BITS (COORD_BITS)
) u_tfs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_tri.valid),
    .i_in_ready  (i_tri.ready),
    .i_out_valid (o_piece.valid),
    .i_out_ready (o_piece.ready),
    .i_out_last  (o_piece.last_piece),
    .i_out_far_x (o_piece.far_x)
);

### verif/tb_top.sv
// Self-checking testbench for the triangle fan subdivider, with its own fan predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tfs_pkg::*;

    localparam int MAX_PIECES = 64;
    localparam int COORD_BITS = 24;
    localparam int TAIL_CYCLES = 16;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [NUM_VERTS-1:0][NUM_AXES-1:0][COORD_BITS-1:0] t_tri;

    typedef struct packed {
        logic [NUM_AXES-1:0][COORD_BITS-1:0] apex;
        logic [NUM_AXES-1:0][COORD_BITS-1:0] near;
        logic [NUM_AXES-1:0][COORD_BITS-1:0] far;
        logic                                last_piece;
    } t_piece;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tfs_cfg_if                              cfg_bus();
    tfs_tri_if   #(.COORD_BITS(COORD_BITS)) tri_bus();
    tfs_piece_if #(.COORD_BITS(COORD_BITS)) piece_bus();

    triangle_fan_subdivide #(
        .MAX_PIECES(MAX_PIECES),
        .COORD_BITS(COORD_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_bus),
        .i_tri  (tri_bus),
        .o_piece(piece_bus)
    );

    // Pieces still to come, oldest first, and the split count the block holds.
    t_piece          expected_pieces[$];
    logic [CFG_W-1:0] cur_split;
    int              mismatch_count;
    int              src_idle_pct;
    int              snk_stall_pct;
    string           axis_name[NUM_AXES] = '{"x", "y", "z"};

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Appends one piece at the tail of the expectation queue.
    function automatic void add_expected(t_piece pc);
        expected_pieces = {expected_pieces, pc};
    endfunction

    // Works out the fan of pieces for one triangle under the current split count.
    function automatic void predict_fan(t_tri t);
        longint n;
        longint j;
        longint p;
        longint q;
        longint cut;
        longint ya;
        longint yb;
        longint yc;
        int     apex;
        int     adj1;
        int     adj2;
        t_piece pc;
        n = (cur_split > MAX_PIECES) ? MAX_PIECES : cur_split;
        // A zero count returns the triangle as it came in.
        if (n == 0) begin
            pc.apex       = t[VTX_A];
            pc.near       = t[VTX_B];
            pc.far        = t[VTX_C];
            pc.last_piece = 1'b1;
            add_expected(pc);
            return;
        end
        ya = $signed(t[VTX_A][AXIS_Y]);
        yb = $signed(t[VTX_B][AXIS_Y]);
        yc = $signed(t[VTX_C][AXIS_Y]);
        // The apex needs a strictly greatest Y; any tie falls back to vertex C.
        if (ya > yb && ya > yc)
            apex = VTX_A;
        else if (yb > ya && yb > yc)
            apex = VTX_B;
        else
            apex = VTX_C;
        adj1 = (apex + 1) % NUM_VERTS;
        adj2 = (apex + 2) % NUM_VERTS;
        for (j = 0; j < n; j++) begin
            pc.apex = t[apex];
            for (int a = 0; a < NUM_AXES; a++) begin
                p = $signed(t[adj1][a]);
                q = $signed(t[adj2][a]);
                cut = p + ((q - p) * j) / n;
                pc.near[a] = cut[COORD_BITS-1:0];
                cut = p + ((q - p) * (j + 1)) / n;
                pc.far[a] = cut[COORD_BITS-1:0];
            end
            pc.last_piece = (j == n - 1);
            add_expected(pc);
        end
    endfunction

    function automatic void check_coord(string what, t_coord want, t_coord got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, $signed(want),
                     $signed(got));
            mismatch_count++;
        end
    endfunction

    // Result side: random stalls on ready, driven at the falling edge.
    initial begin
        piece_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            piece_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Compares every accepted piece with the oldest expectation.
    always @(posedge i_clk) begin : fan_checker
        t_piece got;
        t_piece want;
        if (i_rst_n && piece_bus.valid && piece_bus.ready) begin
            got.apex[AXIS_X] = piece_bus.apex_x;
            got.apex[AXIS_Y] = piece_bus.apex_y;
            got.apex[AXIS_Z] = piece_bus.apex_z;
            got.near[AXIS_X] = piece_bus.near_x;
            got.near[AXIS_Y] = piece_bus.near_y;
            got.near[AXIS_Z] = piece_bus.near_z;
            got.far[AXIS_X]  = piece_bus.far_x;
            got.far[AXIS_Y]  = piece_bus.far_y;
            got.far[AXIS_Z]  = piece_bus.far_z;
            got.last_piece   = piece_bus.last_piece;
            if (expected_pieces.size() == 0) begin
                $display("%0t: piece with none expected, expected nothing, got %h",
                         $time, got);
                mismatch_count++;
            end else begin
                want = expected_pieces.pop_front();
                for (int a = 0; a < NUM_AXES; a++) begin
                    check_coord({"apex_", axis_name[a]}, want.apex[a], got.apex[a]);
                    check_coord({"near_", axis_name[a]}, want.near[a], got.near[a]);
                    check_coord({"far_", axis_name[a]}, want.far[a], got.far[a]);
                end
                if (want.last_piece !== got.last_piece) begin
                    $display("%0t: last_piece expected %0b, got %0b", $time,
                             want.last_piece, got.last_piece);
                    mismatch_count++;
                end
            end
        end
    end

    // Sends one triangle request, with random idle cycles ahead of it.
    task automatic send_triangle(t_tri t);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            tri_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        tri_bus.valid <= 1'b1;
        tri_bus.a_x   <= t[VTX_A][AXIS_X];
        tri_bus.a_y   <= t[VTX_A][AXIS_Y];
        tri_bus.a_z   <= t[VTX_A][AXIS_Z];
        tri_bus.b_x   <= t[VTX_B][AXIS_X];
        tri_bus.b_y   <= t[VTX_B][AXIS_Y];
        tri_bus.b_z   <= t[VTX_B][AXIS_Z];
        tri_bus.c_x   <= t[VTX_C][AXIS_X];
        tri_bus.c_y   <= t[VTX_C][AXIS_Y];
        tri_bus.c_z   <= t[VTX_C][AXIS_Z];
        @(posedge i_clk);
        while (!tri_bus.ready)
            @(posedge i_clk);
        predict_fan(t);
    endtask

    // Drops the request line and waits until every expected piece is back.
    task automatic wait_fan_done();
        @(negedge i_clk);
        tri_bus.valid <= 1'b0;
        while (expected_pieces.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Writes the split count once the block has gone idle.
    task automatic set_split_count(logic [CFG_W-1:0] value);
        wait_fan_done();
        @(negedge i_clk);
        cfg_bus.valid       <= 1'b1;
        cfg_bus.split_count <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        cur_split = value;
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic t_tri make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                      int cx, int cy, int cz);
        t_tri t;
        t[VTX_A][AXIS_X] = ax[COORD_BITS-1:0];
        t[VTX_A][AXIS_Y] = ay[COORD_BITS-1:0];
        t[VTX_A][AXIS_Z] = az[COORD_BITS-1:0];
        t[VTX_B][AXIS_X] = bx[COORD_BITS-1:0];
        t[VTX_B][AXIS_Y] = by[COORD_BITS-1:0];
        t[VTX_B][AXIS_Z] = bz[COORD_BITS-1:0];
        t[VTX_C][AXIS_X] = cx[COORD_BITS-1:0];
        t[VTX_C][AXIS_Y] = cy[COORD_BITS-1:0];
        t[VTX_C][AXIS_Z] = cz[COORD_BITS-1:0];
        return t;
    endfunction

    // Coordinates lean toward the range ends and zero, the rest fully random.
    function automatic t_coord rand_coord();
        case ($urandom_range(7))
            0: return {1'b1, {(COORD_BITS-1){1'b0}}};
            1: return {1'b0, {(COORD_BITS-1){1'b1}}};
            2: return COORD_BITS'($urandom_range(64) - 32);
            default: return COORD_BITS'($urandom());
        endcase
    endfunction

    // Random triangle, often with tied Y values to exercise the apex fallback.
    function automatic t_tri rand_triangle();
        t_tri t;
        for (int v = 0; v < NUM_VERTS; v++)
            for (int a = 0; a < NUM_AXES; a++)
                t[v][a] = rand_coord();
        case ($urandom_range(5))
            0: t[VTX_B][AXIS_Y] = t[VTX_A][AXIS_Y];
            1: t[VTX_C][AXIS_Y] = t[VTX_A][AXIS_Y];
            2: t[VTX_C][AXIS_Y] = t[VTX_B][AXIS_Y];
            3: begin
                t[VTX_B][AXIS_Y] = t[VTX_A][AXIS_Y];
                t[VTX_C][AXIS_Y] = t[VTX_A][AXIS_Y];
            end
            default: ;
        endcase
        return t;
    endfunction

    // Mostly small fans, some large ones, a few counts beyond the maximum.
    function automatic logic [CFG_W-1:0] pick_split();
        case ($urandom_range(19))
            0:                    return '0;
            11, 12, 13, 14, 15:   return CFG_W'($urandom_range(32, 9));
            16, 17:               return CFG_W'($urandom_range(63, 33));
            18:                   return CFG_W'(MAX_PIECES);
            19:                   return CFG_W'($urandom_range(127, 65));
            default:              return CFG_W'($urandom_range(8, 1));
        endcase
    endfunction

    task automatic set_idling(int src_pct, int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    // Zero count: the triangle comes back whole, including at the range ends.
    task automatic test_passthrough();
        set_split_count('0);
        send_triangle(make_tri(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                               8388607, 8388607, 8388607));
        send_triangle(make_tri(-8388608, -8388608, -8388608, -8388608, -8388608,
                               -8388608, -8388608, -8388608, -8388608));
        send_triangle(rand_triangle());
    endtask

    // Apex choice: each vertex strictly on top, then every kind of tie.
    task automatic test_apex_select();
        set_split_count(CFG_W'(3));
        send_triangle(make_tri(10, 100, 20, -300, 50, 40, 700, -5, -60));
        send_triangle(make_tri(10, 50, 20, -300, 100, 40, 700, -5, -60));
        send_triangle(make_tri(10, 50, 20, -300, -5, 40, 700, 100, -60));
        send_triangle(make_tri(10, 100, 20, -300, 100, 40, 700, -5, -60));
        send_triangle(make_tri(10, 100, 20, -300, -5, 40, 700, 100, -60));
        send_triangle(make_tri(10, -5, 20, -300, 100, 40, 700, 100, -60));
        send_triangle(make_tri(10, 7, 20, -300, 7, 40, 700, 7, -60));
    endtask

    // Cut edges spanning the whole range, and short negative spans that truncate.
    task automatic test_edge_extremes();
        set_split_count(CFG_W'(7));
        send_triangle(make_tri(-8388608, -8388608, 8388607, 8388607, 8388606, -8388608,
                               0, 8388607, 0));
        send_triangle(make_tri(8388607, -8388608, -8388608, -8388608, 8388606, 8388607,
                               5, 8388607, -5));
        send_triangle(make_tri(0, -20, 10, -10, -30, -3, 1000, 40, 2000));
    endtask

    // Single piece, the largest fan, and counts that saturate to the largest.
    task automatic test_piece_counts();
        set_split_count(CFG_W'(1));
        send_triangle(rand_triangle());
        set_split_count(CFG_W'(MAX_PIECES));
        send_triangle(rand_triangle());
        set_split_count(CFG_W'(MAX_PIECES + 1));
        send_triangle(rand_triangle());
        set_split_count('1);
        send_triangle(rand_triangle());
    endtask

    // Random triangles in groups, each group with a freshly picked count and one of four idling patterns.
    task automatic test_random_fans();
        for (int grp = 0; grp < 15; grp++) begin
            set_split_count(pick_split());
            case (grp % 4)
                0: set_idling(0, 0);
                1: set_idling(67, 0);
                2: set_idling(0, 67);
                default: set_idling(11, 11);
            endcase
            repeat (30) send_triangle(rand_triangle());
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.split_count = '0;
        tri_bus.valid       = 1'b0;
        tri_bus.a_x         = '0;
        tri_bus.a_y         = '0;
        tri_bus.a_z         = '0;
        tri_bus.b_x         = '0;
        tri_bus.b_y         = '0;
        tri_bus.b_z         = '0;
        tri_bus.c_x         = '0;
        tri_bus.c_y         = '0;
        tri_bus.c_z         = '0;
        cur_split           = '0;
        mismatch_count      = 0;
        set_idling(0, 0);
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_passthrough();
        test_apex_select();
        test_edge_extremes();
        test_piece_counts();
        test_random_fans();
        wait_fan_done();

        if (mismatch_count == 0 && expected_pieces.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Hard stop well beyond the slowest expected run.
    initial begin
        #10ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
